@@ rtl/core/triangle_unit_normal_defines.svh @@
// Assertion macros for the triangle unit normal block.
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`ifndef SYNTHESIS
`define TUN_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tun assertion failed");
`define TUN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tun assertion failed");
`else
`define TUN_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define TUN_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/tun_pkg.sv @@
// Shared widths, stage counts and beat types of the triangle unit normal block.
package tun_pkg;
   localparam int COORD_W    = 16;
   localparam int EDGE_W     = 17;
   localparam int PROD_W     = 34;
   localparam int CROSS_W    = 35;
   localparam int MAG_W      = 34;
   localparam int HALF_W     = 17;
   localparam int SQ_W       = 68;
   localparam int QUO_W      = 31;
   localparam int RAD_W      = 32;
   localparam int ROOT_W     = 16;
   localparam int SQRT_REM_W = 18;
   localparam int OUT_W      = 16;
   localparam int MAG_OUT_W  = 15;

   localparam int FRONT_STAGES = 6;
   localparam int DIV_STEPS    = QUO_W;
   localparam int SQRT_STEPS   = ROOT_W;
   localparam int PIPE_LAT     = FRONT_STAGES + DIV_STEPS + SQRT_STEPS + 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] az;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by_coord;
      logic signed [COORD_W-1:0] bz;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
      logic signed [COORD_W-1:0] cz;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] nx;
      logic signed [OUT_W-1:0] ny;
      logic signed [OUT_W-1:0] nz;
      logic                    degenerate;
   } rsp_type;

   typedef struct packed {
      logic neg;
      logic degen;
   } tag_type;

   typedef struct packed {
      logic [SQ_W-1:0] c2;
      tag_type         tag;
   } comp_type;

   typedef struct packed {
      logic            valid;
      logic [SQ_W-1:0] s;
      comp_type [2:0]  comp;
   } front_type;
endpackage

@@ rtl/core/tun_front.sv @@
// Edge vectors, cross product, component squares and squared length.
module tun_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  tun_pkg::req_type    in_data,
   output tun_pkg::front_type  out
);
   logic [tun_pkg::FRONT_STAGES-1:0] vld_ff, vld_in;

   logic signed [tun_pkg::EDGE_W-1:0]  u_ff [3], u_in [3], v_ff [3], v_in [3];
   logic signed [tun_pkg::PROD_W-1:0]  prod_ff [6], prod_in [6];
   logic [tun_pkg::MAG_W-1:0]          mag_ff [3], mag_in [3];
   logic                               neg_c_ff [3], neg_c_in [3];
   logic [2*tun_pkg::HALF_W-1:0]       hh_ff [3], hh_in [3], hl_ff [3], hl_in [3];
   logic [2*tun_pkg::HALF_W-1:0]       ll_ff [3], ll_in [3];
   tun_pkg::tag_type                   tag_d_ff [3], tag_d_in [3];
   tun_pkg::tag_type                   tag_e_ff [3], tag_e_in [3];
   tun_pkg::tag_type                   tag_f_ff [3], tag_f_in [3];
   logic [tun_pkg::SQ_W-1:0]           sq_ff [3], sq_in [3], c2_ff [3], c2_in [3];
   logic [tun_pkg::SQ_W-1:0]           s_ff, s_in;

   always_comb begin
      logic signed [tun_pkg::CROSS_W-1:0] n;
      logic [tun_pkg::HALF_W-1:0]         hi, lo;
      logic                               all_zero;

      vld_in = {vld_ff[tun_pkg::FRONT_STAGES-2:0], in_valid};

      u_in[0] = tun_pkg::EDGE_W'(in_data.ax) - tun_pkg::EDGE_W'(in_data.bx);
      u_in[1] = tun_pkg::EDGE_W'(in_data.ay) - tun_pkg::EDGE_W'(in_data.by_coord);
      u_in[2] = tun_pkg::EDGE_W'(in_data.az) - tun_pkg::EDGE_W'(in_data.bz);
      v_in[0] = tun_pkg::EDGE_W'(in_data.ax) - tun_pkg::EDGE_W'(in_data.cx);
      v_in[1] = tun_pkg::EDGE_W'(in_data.ay) - tun_pkg::EDGE_W'(in_data.cy);
      v_in[2] = tun_pkg::EDGE_W'(in_data.az) - tun_pkg::EDGE_W'(in_data.cz);

      prod_in[0] = u_ff[1] * v_ff[2];
      prod_in[1] = v_ff[1] * u_ff[2];
      prod_in[2] = u_ff[2] * v_ff[0];
      prod_in[3] = v_ff[2] * u_ff[0];
      prod_in[4] = u_ff[0] * v_ff[1];
      prod_in[5] = v_ff[0] * u_ff[1];

      all_zero = 1'b1;
      for (int k = 0; k < 3; k++) begin
         n = tun_pkg::CROSS_W'(prod_ff[2*k]) - tun_pkg::CROSS_W'(prod_ff[2*k+1]);
         neg_c_in[k] = n[tun_pkg::CROSS_W-1];
         mag_in[k] = n[tun_pkg::CROSS_W-1] ? tun_pkg::MAG_W'(-n) : tun_pkg::MAG_W'(n);

         hi = mag_ff[k][tun_pkg::MAG_W-1:tun_pkg::HALF_W];
         lo = mag_ff[k][tun_pkg::HALF_W-1:0];
         hh_in[k] = hi * hi;
         hl_in[k] = hi * lo;
         ll_in[k] = lo * lo;
         if (mag_ff[k] != '0) begin
            all_zero = 1'b0;
         end

         // a^2 = hi^2 * 2^34 + 2*hi*lo * 2^17 + lo^2
         sq_in[k] = (tun_pkg::SQ_W'(hh_ff[k]) << (2*tun_pkg::HALF_W))
                  + (tun_pkg::SQ_W'(hl_ff[k]) << (tun_pkg::HALF_W+1))
                  + tun_pkg::SQ_W'(ll_ff[k]);
         tag_e_in[k] = tag_d_ff[k];

         c2_in[k]    = sq_ff[k];
         tag_f_in[k] = tag_e_ff[k];
      end
      for (int k = 0; k < 3; k++) begin
         tag_d_in[k].neg   = neg_c_ff[k];
         tag_d_in[k].degen = all_zero;
      end
      s_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      u_ff     <= u_in;
      v_ff     <= v_in;
      prod_ff  <= prod_in;
      mag_ff   <= mag_in;
      neg_c_ff <= neg_c_in;
      hh_ff    <= hh_in;
      hl_ff    <= hl_in;
      ll_ff    <= ll_in;
      tag_d_ff <= tag_d_in;
      sq_ff    <= sq_in;
      tag_e_ff <= tag_e_in;
      c2_ff    <= c2_in;
      tag_f_ff <= tag_f_in;
      s_ff     <= s_in;
   end

   always_comb begin
      out.valid = vld_ff[tun_pkg::FRONT_STAGES-1];
      out.s     = s_ff;
      for (int k = 0; k < 3; k++) begin
         out.comp[k].c2  = c2_ff[k];
         out.comp[k].tag = tag_f_ff[k];
      end
   end
endmodule

@@ rtl/core/tun_div.sv @@
// Restoring divider, one quotient bit per stage: floor(c2 * 2^30 / s).
module tun_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [tun_pkg::SQ_W-1:0]      in_c2,
   input  logic [tun_pkg::SQ_W-1:0]      in_s,
   input  tun_pkg::tag_type              in_tag,
   output logic                          out_valid,
   output logic [tun_pkg::QUO_W-1:0]     out_quo,
   output tun_pkg::tag_type              out_tag
);
   localparam int N = tun_pkg::DIV_STEPS;

   logic [N-1:0]                  vld_ff, vld_in;
   logic [tun_pkg::SQ_W-1:0]      rem_ff [N], rem_in [N];
   logic [tun_pkg::SQ_W-1:0]      s_ff [N], s_in [N];
   logic [tun_pkg::QUO_W-1:0]     quo_ff [N], quo_in [N];
   tun_pkg::tag_type              tag_ff [N], tag_in [N];

   always_comb begin
      logic [tun_pkg::SQ_W:0] twice, diff;
      logic                   take;

      // c2 <= s, so the first step leaves the remainder below s
      take      = in_c2 >= in_s;
      rem_in[0] = take ? in_c2 - in_s : in_c2;
      quo_in[0] = tun_pkg::QUO_W'(take);
      s_in[0]   = in_s;
      tag_in[0] = in_tag;
      vld_in    = {vld_ff[N-2:0], in_valid};
      for (int k = 1; k < N; k++) begin
         twice     = {rem_ff[k-1], 1'b0};
         diff      = twice - {1'b0, s_ff[k-1]};
         take      = twice >= {1'b0, s_ff[k-1]};
         rem_in[k] = take ? diff[tun_pkg::SQ_W-1:0] : twice[tun_pkg::SQ_W-1:0];
         quo_in[k] = {quo_ff[k-1][tun_pkg::QUO_W-2:0], take};
         s_in[k]   = s_ff[k-1];
         tag_in[k] = tag_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      rem_ff <= rem_in;
      s_ff   <= s_in;
      quo_ff <= quo_in;
      tag_ff <= tag_in;
   end

   assign out_valid = vld_ff[N-1];
   assign out_quo   = quo_ff[N-1];
   assign out_tag   = tag_ff[N-1];
endmodule

@@ rtl/core/tun_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per stage.
module tun_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [tun_pkg::RAD_W-1:0]     in_rad,
   input  tun_pkg::tag_type              in_tag,
   output logic                          out_valid,
   output logic [tun_pkg::ROOT_W-1:0]    out_root,
   output tun_pkg::tag_type              out_tag
);
   localparam int N   = tun_pkg::SQRT_STEPS;
   localparam int RW  = tun_pkg::SQRT_REM_W;
   localparam int CW  = RW + 2;

   logic [N-1:0]                  vld_ff, vld_in;
   logic [RW-1:0]                 rem_ff [N], rem_in [N];
   logic [tun_pkg::ROOT_W-1:0]    root_ff [N], root_in [N];
   logic [tun_pkg::RAD_W-1:0]     rad_ff [N], rad_in [N];
   tun_pkg::tag_type              tag_ff [N], tag_in [N];

   always_comb begin
      logic [RW-1:0]                 rem_prev;
      logic [tun_pkg::ROOT_W-1:0]    root_prev;
      logic [tun_pkg::RAD_W-1:0]     rad_prev;
      logic [CW-1:0]                 cur, trial, diff;
      logic                          take;

      vld_in = {vld_ff[N-2:0], in_valid};
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            rem_prev  = '0;
            root_prev = '0;
            rad_prev  = in_rad;
            tag_in[k] = in_tag;
         end else begin
            rem_prev  = rem_ff[k-1];
            root_prev = root_ff[k-1];
            rad_prev  = rad_ff[k-1];
            tag_in[k] = tag_ff[k-1];
         end
         cur        = {rem_prev, rad_prev[tun_pkg::RAD_W-1 -: 2]};
         trial      = {{(CW-tun_pkg::ROOT_W-2){1'b0}}, root_prev, 2'b01};
         diff       = cur - trial;
         take       = cur >= trial;
         rem_in[k]  = take ? diff[RW-1:0] : cur[RW-1:0];
         root_in[k] = {root_prev[tun_pkg::ROOT_W-2:0], take};
         rad_in[k]  = rad_prev << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      rem_ff  <= rem_in;
      root_ff <= root_in;
      rad_ff  <= rad_in;
      tag_ff  <= tag_in;
   end

   assign out_valid = vld_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_tag   = tag_ff[N-1];
endmodule

@@ rtl/core/triangle_unit_normal.sv @@
// Top level of the triangle unit normal block.
// Takes one triangle every clock (busy never rises) and returns its unit face
// normal in signed Q1.14; the result is shown for one cycle under rsp_valid
// and cannot be held off. The pipeline is six front stages (edges, cross
// product, squares, length), a 31-stage restoring divider per component, a
// 16-stage square root per component and one output register. Collinear
// points give degenerate = 1 and a zero normal.
`include "triangle_unit_normal_defines.svh"
module triangle_unit_normal (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tun_pkg::req_type  req_data,
   output logic              rsp_valid,
   output tun_pkg::rsp_type  rsp_data
);
   tun_pkg::front_type                front;
   logic [2:0]                        div_vld, sqrt_vld;
   logic [tun_pkg::QUO_W-1:0]         quo [3];
   logic [tun_pkg::ROOT_W-1:0]        root [3];
   tun_pkg::tag_type                  div_tag [3], sqrt_tag [3];

   logic                              rsp_valid_ff, rsp_valid_in;
   tun_pkg::rsp_type                  rsp_ff, rsp_in;

   assign busy = 1'b0;

   tun_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start && !busy),
      .in_data  (req_data),
      .out      (front)
   );

   for (genvar k = 0; k < 3; k++) begin : g_comp
      tun_div u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (front.valid),
         .in_c2     (front.comp[k].c2),
         .in_s      (front.s),
         .in_tag    (front.comp[k].tag),
         .out_valid (div_vld[k]),
         .out_quo   (quo[k]),
         .out_tag   (div_tag[k])
      );

      tun_sqrt u_sqrt (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_vld[k]),
         .in_rad    ({1'b0, quo[k]}),
         .in_tag    (div_tag[k]),
         .out_valid (sqrt_vld[k]),
         .out_root  (root[k]),
         .out_tag   (sqrt_tag[k])
      );
   end

   always_comb begin
      logic [tun_pkg::ROOT_W:0]        rnd;
      logic [tun_pkg::MAG_OUT_W-1:0]   mag;
      logic signed [tun_pkg::OUT_W-1:0] val [3];

      // largest q with (2q-1)^2 <= quotient is (isqrt + 1) / 2
      for (int k = 0; k < 3; k++) begin
         rnd = {1'b0, root[k]} + 1'b1;
         mag = rnd[tun_pkg::MAG_OUT_W:1];
         if (sqrt_tag[k].degen) begin
            val[k] = '0;
         end else if (sqrt_tag[k].neg) begin
            val[k] = -tun_pkg::OUT_W'(mag);
         end else begin
            val[k] = tun_pkg::OUT_W'(mag);
         end
      end
      rsp_valid_in       = sqrt_vld[0];
      rsp_in.nx          = val[0];
      rsp_in.ny          = val[1];
      rsp_in.nz          = val[2];
      rsp_in.degenerate  = sqrt_tag[0].degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `TUN_ASSERT_IMPL(a_latency, clock, reset, start && !busy, ##(tun_pkg::PIPE_LAT) rsp_valid)
   `TUN_ASSERT_IMPL(a_degen_zero, clock, reset, rsp_valid && rsp_data.degenerate, (rsp_data.nx == '0) && (rsp_data.ny == '0) && (rsp_data.nz == '0))
   `TUN_ASSERT_IMPL(a_range, clock, reset, rsp_valid, (rsp_data.nx >= -16'sd16384) && (rsp_data.nx <= 16'sd16384) && (rsp_data.ny >= -16'sd16384) && (rsp_data.ny <= 16'sd16384))
   `TUN_ASSERT_NEXT(a_lanes_aligned, clock, reset, front.valid, 1'b1 ##(tun_pkg::DIV_STEPS + tun_pkg::SQRT_STEPS - 1) (sqrt_vld == 3'b111))
endmodule

@@ sim/triangle_unit_normal_test.sv @@
// Testbench for the triangle unit normal block: scoreboard predictor plus random stimulus.
`timescale 1ns / 1ps
module triangle_unit_normal_test;

   // Expected normals, oldest first, with an exact predictor.
   class normal_board;
      tun_pkg::rsp_type pending[$];
      int               errors;

      function new();
         errors = 0;
      endfunction

      // largest q in [0,16384] with (2q-1)^2 * s <= c^2 * 2^30
      function logic signed [15:0] round_comp(longint c, logic [127:0] s);
         logic [127:0] mag, rhs, t;
         int lo, hi, mid;
         mag = (c < 0) ? -c : c;
         rhs = (mag * mag) << 30;
         lo = 0;
         hi = 16384;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 2 * mid - 1;
            if (s * t * t <= rhs) lo = mid;
            else hi = mid - 1;
         end
         return (c < 0) ? 16'(-lo) : 16'(lo);
      endfunction

      function void note_triangle(tun_pkg::req_type r);
         longint ux, uy, uz, vx, vy, vz, n0, n1, n2;
         logic signed [127:0] w0, w1, w2;
         logic [127:0] s;
         tun_pkg::rsp_type e;
         ux = longint'(r.ax) - longint'(r.bx);
         uy = longint'(r.ay) - longint'(r.by_coord);
         uz = longint'(r.az) - longint'(r.bz);
         vx = longint'(r.ax) - longint'(r.cx);
         vy = longint'(r.ay) - longint'(r.cy);
         vz = longint'(r.az) - longint'(r.cz);
         n0 = uy * vz - vy * uz;
         n1 = uz * vx - vz * ux;
         n2 = ux * vy - vx * uy;
         // squares exceed 64 bits, so widen before multiplying
         w0 = 128'(n0);
         w1 = 128'(n1);
         w2 = 128'(n2);
         s = w0 * w0 + w1 * w1 + w2 * w2;
         if (s == 0) begin
            e = '0;
            e.degenerate = 1'b1;
         end else begin
            e.nx = round_comp(n0, s);
            e.ny = round_comp(n1, s);
            e.nz = round_comp(n2, s);
            e.degenerate = 1'b0;
         end
         pending.push_back(e);
      endfunction

      function void check_normal(tun_pkg::rsp_type got);
         tun_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %p", $time, got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.nx !== e.nx || got.ny !== e.ny || got.nz !== e.nz
             || got.degenerate !== e.degenerate) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, e, got);
            errors++;
         end
      endfunction
   endclass

   logic             clock = 0;
   logic             reset = 1;
   logic             start = 0;
   logic             busy;
   tun_pkg::req_type req_data = '0;
   logic             rsp_valid;
   tun_pkg::rsp_type rsp_data;
   normal_board      board = new();

   triangle_unit_normal dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_normal(rsp_data);
   end

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(0, 15)) - 8);
         3: return 16'($signed($urandom_range(0, 511)) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   // one beat, with a random gap before it when gaps is set; start stays high for back to back beats
   task automatic send_triangle(tun_pkg::req_type r, bit gaps);
      int wait_n;
      wait_n = gaps ? $urandom_range(0, 14) : 0;
      if (wait_n > 0) begin
         start <= 1'b0;
         repeat (wait_n) @(negedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_triangle(r);
      @(negedge clock);
   endtask

   task automatic run_random(int n);
      tun_pkg::req_type r;
      bit gaps;
      gaps = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (i % 100 == 0) gaps = $urandom_range(0, 2) != 0;
         r = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
              pick_coord(), pick_coord(), pick_coord(), pick_coord()};
         case ($urandom_range(0, 9))
            0: begin r.bx = r.ax; r.by_coord = r.ay; r.bz = r.az; end // coincident
            1: begin r.cx = r.bx; r.cy = r.by_coord; r.cz = r.bz; end
            2: begin r.az = '0; r.bz = '0; r.cz = '0; end              // axis normal
            default: ;
         endcase
         send_triangle(r, gaps);
      end
   endtask

   initial begin
      int idle;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: unit triangles, extremes, collinear, coincident
      send_triangle('0, 0);
      send_triangle({16'h0, 16'h0, 16'h0, 16'h100, 16'h0, 16'h0, 16'h0, 16'h100,
                     16'h0}, 0);
      send_triangle({16'h0, 16'h0, 16'h0, 16'h0, 16'h100, 16'h0, 16'h0, 16'h0,
                     16'h100}, 0);
      send_triangle({16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h100, 16'h100, 16'h0,
                     16'h0}, 1);
      send_triangle({16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
                     16'h7fff, 16'h8000, 16'h7fff}, 0);
      send_triangle({16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
                     16'h8000, 16'h7fff, 16'h8000}, 0);
      send_triangle({16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                     16'h8000, 16'h7fff, 16'h8000}, 1);
      send_triangle({16'h0, 16'h0, 16'h0, 16'h100, 16'h100, 16'h100, 16'h200,
                     16'h200, 16'h200}, 0); // collinear
      send_triangle({16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                     16'hffff, 16'hffff, 16'hffff}, 0);
      send_triangle({16'h1, 16'h0, 16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 16'h0,
                     16'h1}, 0);
      send_triangle({16'h7fff, 16'h8000, 16'h0, 16'h8000, 16'h7fff, 16'h0,
                     16'h0, 16'h0, 16'h7fff}, 1);
      send_triangle({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                     16'h1234, 16'hedcb, 16'h0f0f}, 0);
      run_random(1250);
      start <= 1'b0;
      idle = 0;
      while (board.pending.size() != 0 && idle < 2000) begin
         @(posedge clock);
         idle++;
      end
      repeat (tun_pkg::PIPE_LAT + 10) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/tun_pkg.sv
rtl/core/tun_front.sv
rtl/core/tun_div.sv
rtl/core/tun_sqrt.sv
rtl/core/triangle_unit_normal.sv
sim/triangle_unit_normal_test.sv
